// ===== hdl/mqttp_pkg.sv =====
// Shared types, codes and constants for the MQTT receive parser.
package mqttp_pkg;

	localparam int MAX_LENGTH_GROUPS = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_OPEN  = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	localparam logic [3:0] TYPE_CONNACK = 4'd2;
	localparam logic [3:0] TYPE_PUBLISH = 4'd3;
	localparam logic [3:0] TYPE_PINGREQ = 4'd12;

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_LENGTH   = 3'd1,
		PH_SKIP     = 3'd2,
		PH_TOPIC_HI = 3'd3,
		PH_TOPIC_LO = 3'd4,
		PH_TOPIC    = 3'd5,
		PH_ID       = 3'd6,
		PH_PAYLOAD  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		LINK_DOWN       = 2'd0,
		LINK_CONNECTING = 2'd1,
		LINK_UP         = 2'd2
	} link_t;

	typedef enum logic [2:0] {
		K_TOPIC        = 3'd0,
		K_PAYLOAD      = 3'd1,
		K_EMPTY_END    = 3'd2,
		K_CONNECTED    = 3'd3,
		K_SEND_DISC    = 3'd4,
		K_DISCONNECTED = 3'd5,
		K_SEND_PINGRSP = 3'd6,
		K_MALFORMED    = 3'd7
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [1:0] qos;
		logic       eom;
	} res_t;

	// Results caused by one input item: up to two.
	typedef struct packed {
		res_t       r0;
		res_t       r1;
		logic [1:0] n;
	} pair_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] d, logic [1:0] q, logic e);
		res_t r;
		r.kind = k;
		r.data = d;
		r.qos  = q;
		r.eom  = e;
		return r;
	endfunction

	function automatic pair_t add_res(pair_t p, res_t r);
		pair_t o;
		o = p;
		if (p.n == 2'd0) begin
			o.r0 = r;
		end else begin
			o.r1 = r;
		end
		o.n = p.n + 2'd1;
		return o;
	endfunction

endpackage

// ===== hdl/mqttp_front.sv =====
// Front end: accepts input items, runs the header/body parser, emits result pairs.
module mqttp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           operation,
	input  logic [7:0]           rx_byte,
	output logic                 push,
	output mqttp_pkg::pair_t     push_pair
);

	mqttp_pkg::link_t  link_q, link_d;
	mqttp_pkg::phase_t phase_q, phase_d;
	logic [3:0]  type_q, type_d;
	logic [1:0]  qos_q, qos_d;
	logic [27:0] rlen_q, rlen_d;
	logic [2:0]  grp_q, grp_d;
	logic [27:0] body_q, body_d;
	logic [15:0] topic_q, topic_d;
	logic [7:0]  tlh_q, tlh_d;
	logic [1:0]  id_q, id_d;
	logic [7:0]  code_q, code_d;
	logic        pubv_q, pubv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= mqttp_pkg::LINK_DOWN;
			phase_q <= mqttp_pkg::PH_HEADER;
			type_q  <= '0;
			qos_q   <= '0;
			rlen_q  <= '0;
			grp_q   <= '0;
			body_q  <= '0;
			topic_q <= '0;
			tlh_q   <= '0;
			id_q    <= '0;
			code_q  <= '0;
			pubv_q  <= 1'b0;
		end else if (accept) begin
			link_q  <= link_d;
			phase_q <= phase_d;
			type_q  <= type_d;
			qos_q   <= qos_d;
			rlen_q  <= rlen_d;
			grp_q   <= grp_d;
			body_q  <= body_d;
			topic_q <= topic_d;
			tlh_q   <= tlh_d;
			id_q    <= id_d;
			code_q  <= code_d;
			pubv_q  <= pubv_d;
		end
	end

	logic [27:0] add_grp;
	logic [27:0] rlen_sum;
	logic [2:0]  grp_inc;
	logic [27:0] body_dec;
	logic        last;
	logic [15:0] tl;
	logic [15:0] topic_dec;
	logic [1:0]  id_dec;
	logic [7:0]  code_new;
	logic        do_close;
	logic        do_finish;
	logic        do_after;
	mqttp_pkg::pair_t p;

	always_comb begin
		unique case (grp_q)
			3'd0:    add_grp = {21'd0, rx_byte[6:0]};
			3'd1:    add_grp = {14'd0, rx_byte[6:0], 7'd0};
			3'd2:    add_grp = {7'd0, rx_byte[6:0], 14'd0};
			3'd3:    add_grp = {rx_byte[6:0], 21'd0};
			default: add_grp = '0;
		endcase
	end

	assign rlen_sum  = rlen_q + add_grp;
	assign grp_inc   = grp_q + 3'd1;
	assign body_dec  = body_q - 28'd1;
	assign last      = (body_dec == 28'd0);
	assign tl        = {tlh_q, rx_byte};
	assign topic_dec = topic_q - 16'd1;
	assign id_dec    = id_q - 2'd1;

	always_comb begin
		link_d    = link_q;
		phase_d   = phase_q;
		type_d    = type_q;
		qos_d     = qos_q;
		rlen_d    = rlen_q;
		grp_d     = grp_q;
		body_d    = body_q;
		topic_d   = topic_q;
		tlh_d     = tlh_q;
		id_d      = id_q;
		code_d    = code_q;
		pubv_d    = pubv_q;
		code_new  = code_q;
		do_close  = 1'b0;
		do_finish = 1'b0;
		do_after  = 1'b0;
		p         = '0;

		priority if (operation == mqttp_pkg::OP_BYTE) begin
			if (link_q != mqttp_pkg::LINK_DOWN) begin
				unique case (phase_q)
					mqttp_pkg::PH_HEADER: begin
						type_d  = rx_byte[7:4];
						qos_d   = rx_byte[2:1];
						rlen_d  = '0;
						grp_d   = '0;
						pubv_d  = 1'b0;
						code_d  = '0;
						phase_d = mqttp_pkg::PH_LENGTH;
					end
					mqttp_pkg::PH_LENGTH: begin
						rlen_d = rlen_sum;
						grp_d  = grp_inc;
						if (!rx_byte[7]) begin
							body_d = rlen_sum;
							if (rlen_sum == 28'd0) begin
								code_new  = 8'd0;
								do_finish = 1'b1;
							end else if (type_q == mqttp_pkg::TYPE_PUBLISH) begin
								phase_d = mqttp_pkg::PH_TOPIC_HI;
							end else begin
								phase_d = mqttp_pkg::PH_SKIP;
							end
						end else if (grp_inc >= 3'(mqttp_pkg::MAX_LENGTH_GROUPS)) begin
							p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
								mqttp_pkg::K_MALFORMED, 8'd0, 2'd0, 1'b0));
							phase_d = mqttp_pkg::PH_HEADER;
						end
					end
					mqttp_pkg::PH_SKIP: begin
						body_d = body_dec;
						// second body byte of a CONNACK is its return code
						if (type_q == mqttp_pkg::TYPE_CONNACK && rlen_q == body_q + 28'd1) begin
							code_new = rx_byte;
							code_d   = rx_byte;
						end
						if (last) begin
							do_finish = 1'b1;
						end
					end
					mqttp_pkg::PH_TOPIC_HI: begin
						body_d  = body_dec;
						tlh_d   = rx_byte;
						phase_d = last ? mqttp_pkg::PH_HEADER : mqttp_pkg::PH_TOPIC_LO;
					end
					mqttp_pkg::PH_TOPIC_LO: begin
						body_d = body_dec;
						if ({12'd0, tl} > body_dec) begin
							pubv_d  = 1'b0;
							phase_d = last ? mqttp_pkg::PH_HEADER : mqttp_pkg::PH_SKIP;
						end else begin
							pubv_d  = 1'b1;
							topic_d = tl;
							if (tl != 16'd0) begin
								phase_d = mqttp_pkg::PH_TOPIC;
							end else begin
								do_after = 1'b1;
							end
						end
					end
					mqttp_pkg::PH_TOPIC: begin
						body_d  = body_dec;
						p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
							mqttp_pkg::K_TOPIC, rx_byte, qos_q, 1'b0));
						topic_d = topic_dec;
						if (topic_dec == 16'd0) begin
							do_after = 1'b1;
						end else if (last) begin
							phase_d = mqttp_pkg::PH_HEADER;
						end
					end
					mqttp_pkg::PH_ID: begin
						body_d = body_dec;
						id_d   = id_dec;
						if (last) begin
							p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
								mqttp_pkg::K_EMPTY_END, 8'd0, qos_q, 1'b1));
							phase_d = mqttp_pkg::PH_HEADER;
						end else if (id_dec == 2'd0) begin
							phase_d = mqttp_pkg::PH_PAYLOAD;
						end
					end
					mqttp_pkg::PH_PAYLOAD: begin
						body_d = body_dec;
						p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
							mqttp_pkg::K_PAYLOAD, rx_byte, qos_q, last));
						if (last) begin
							phase_d = mqttp_pkg::PH_HEADER;
						end
					end
					default: phase_d = mqttp_pkg::PH_HEADER;
				endcase
			end
		end else if (operation == mqttp_pkg::OP_OPEN) begin
			if (link_q == mqttp_pkg::LINK_DOWN) begin
				link_d  = mqttp_pkg::LINK_CONNECTING;
				phase_d = mqttp_pkg::PH_HEADER;
				type_d  = '0;
				qos_d   = '0;
				rlen_d  = '0;
				grp_d   = '0;
				body_d  = '0;
				topic_d = '0;
				tlh_d   = '0;
				id_d    = '0;
				code_d  = '0;
				pubv_d  = 1'b0;
			end
		end else if (operation == mqttp_pkg::OP_CLOSE) begin
			do_close = 1'b1;
		end else begin
			// unused operation code: no effect
			do_close = 1'b0;
		end

		// end of topic: empty payload or move on to id/payload
		if (do_after) begin
			if (body_dec == 28'd0) begin
				p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
					mqttp_pkg::K_EMPTY_END, 8'd0, qos_q, 1'b1));
				phase_d = mqttp_pkg::PH_HEADER;
			end else if (qos_q != 2'd0 && body_dec >= 28'd2) begin
				id_d    = 2'd2;
				phase_d = mqttp_pkg::PH_ID;
			end else begin
				id_d    = 2'd0;
				phase_d = mqttp_pkg::PH_PAYLOAD;
			end
		end

		// completion of a packet that is not streamed
		if (do_finish) begin
			phase_d = mqttp_pkg::PH_HEADER;
			if (type_q == mqttp_pkg::TYPE_CONNACK && rlen_d >= 28'd2) begin
				if (code_new == 8'd0) begin
					link_d = mqttp_pkg::LINK_UP;
					p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
						mqttp_pkg::K_CONNECTED, 8'd0, 2'd0, 1'b0));
				end else begin
					do_close = 1'b1;
				end
			end else if (type_q == mqttp_pkg::TYPE_PINGREQ) begin
				p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
					mqttp_pkg::K_SEND_PINGRSP, 8'd0, 2'd0, 1'b0));
			end
		end

		if (do_close && link_q != mqttp_pkg::LINK_DOWN) begin
			if (link_d == mqttp_pkg::LINK_UP || link_q == mqttp_pkg::LINK_UP) begin
				p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
					mqttp_pkg::K_SEND_DISC, 8'd0, 2'd0, 1'b0));
			end
			link_d  = mqttp_pkg::LINK_DOWN;
			phase_d = mqttp_pkg::PH_HEADER;
			type_d  = '0;
			qos_d   = '0;
			rlen_d  = '0;
			grp_d   = '0;
			body_d  = '0;
			topic_d = '0;
			tlh_d   = '0;
			id_d    = '0;
			code_d  = '0;
			pubv_d  = 1'b0;
			p = mqttp_pkg::add_res(p, mqttp_pkg::mk_res(
				mqttp_pkg::K_DISCONNECTED, 8'd0, 2'd0, 1'b0));
		end
	end

	assign push      = accept && (p.n != 2'd0);
	assign push_pair = p;

endmodule

// ===== hdl/mqttp_queue.sv =====
// Short queue of result pairs between the parser and the output stage.
module mqttp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mqttp_pkg::pair_t  push_pair,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output mqttp_pkg::pair_t  head
);

	mqttp_pkg::pair_t mem_q [mqttp_pkg::QUEUE_DEPTH];
	logic [mqttp_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [mqttp_pkg::QCNT_W-1:0] cnt_q;

	localparam logic [mqttp_pkg::QPTR_W-1:0] LAST_PTR =
		mqttp_pkg::QPTR_W'(mqttp_pkg::QUEUE_DEPTH - 1);
	localparam logic [mqttp_pkg::QPTR_W-1:0] PTR_ONE = mqttp_pkg::QPTR_W'(1);
	localparam logic [mqttp_pkg::QCNT_W-1:0] CNT_ONE = mqttp_pkg::QCNT_W'(1);

	assign full  = (cnt_q == mqttp_pkg::QCNT_W'(mqttp_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_ONE;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_ONE;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_ONE;
				2'b01:   cnt_q <= cnt_q - CNT_ONE;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/mqttp_back.sv =====
// Back end: splits queued result pairs into single output items in a register.
module mqttp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  mqttp_pkg::pair_t  q_head,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output mqttp_pkg::res_t   out_res
);

	logic            valid_q;
	logic            pend_q;
	mqttp_pkg::res_t res_q;
	mqttp_pkg::res_t second_q;
	logic            free;

	assign free      = !valid_q || !out_stall;
	assign pop       = free && !pend_q && !q_empty;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (free) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= !q_empty;
				pend_q  <= !q_empty && (q_head.n == 2'd2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (pend_q) begin
				res_q <= second_q;
			end else if (!q_empty) begin
				res_q    <= q_head.r0;
				second_q <= q_head.r1;
			end
		end
	end

endmodule

// ===== hdl/mqtt_receive_packet_parser.sv =====
// Top level: MQTT 3.1.1 client receive parser, parser front end, queue, output stage.
// Takes one input item per cycle; in_stall rises only when the result queue is full.
// A result passes through the result queue and the output register before it appears.
// An item with two results (such as a close while connected, or a last topic byte
// with an empty payload) puts them out one after the other. Reset (arst_n low) sets the link
// disconnected, the parser to await a header byte, and empties the queue and output register.
module mqtt_receive_packet_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] data_byte,
	output logic [1:0] qos_level,
	output logic       end_of_message
);

	logic             accept;
	logic             push;
	mqttp_pkg::pair_t push_pair;
	logic             q_full;
	logic             q_empty;
	logic             pop;
	mqttp_pkg::pair_t q_head;
	mqttp_pkg::res_t  res;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	mqttp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_pair (push_pair)
	);

	mqttp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pair (push_pair),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	mqttp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (res)
	);

	assign kind           = res.kind;
	assign data_byte      = res.data;
	assign qos_level      = res.qos;
	assign end_of_message = res.eom;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the MQTT receive parser: directed and random byte streams, checked against a mirror.
module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] operation = mqttp_pkg::OP_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] data_byte;
	logic [1:0] qos_level;
	logic       end_of_message;

	mqtt_receive_packet_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.qos_level(qos_level),
		.end_of_message(end_of_message)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the parser state
	mqttp_pkg::link_t  m_link;
	mqttp_pkg::phase_t m_phase;
	logic [3:0]  m_type;
	logic [1:0]  m_qos;
	logic [27:0] m_len;
	logic [2:0]  m_groups;
	logic [27:0] m_body_left;
	logic [15:0] m_topic_left;
	logic [7:0]  m_topic_hi;
	logic [1:0]  m_id_left;
	logic [7:0]  m_ack_code;
	logic        m_pub_ok;

	mqttp_pkg::res_t due_results[$];
	int   step_results;
	int   useful_items = 0;
	int   burst_left = 0;
	int   fail_count = 0;
	int   results_seen = 0;
	logic [7:0] pkt_bytes[$];

	task automatic add_due(mqttp_pkg::kind_t k, logic [7:0] d, logic [1:0] q, logic e);
		mqttp_pkg::res_t r;
		if (step_results < 2) begin
			r.kind = k;
			r.data = d;
			r.qos  = q;
			r.eom  = e;
			due_results = {due_results, r};
			step_results++;
		end
	endtask

	task automatic add_byte(logic [7:0] b);
		pkt_bytes = {pkt_bytes, b};
	endtask

	task automatic clear_mirror;
		m_phase      = mqttp_pkg::PH_HEADER;
		m_type       = '0;
		m_qos        = '0;
		m_len        = '0;
		m_groups     = '0;
		m_body_left  = '0;
		m_topic_left = '0;
		m_topic_hi   = '0;
		m_id_left    = '0;
		m_ack_code   = '0;
		m_pub_ok     = 1'b0;
	endtask

	task automatic drop_link;
		if (m_link == mqttp_pkg::LINK_DOWN) return;
		if (m_link == mqttp_pkg::LINK_UP) add_due(mqttp_pkg::K_SEND_DISC, 8'h00, 2'd0, 1'b0);
		m_link = mqttp_pkg::LINK_DOWN;
		clear_mirror();
		add_due(mqttp_pkg::K_DISCONNECTED, 8'h00, 2'd0, 1'b0);
	endtask

	// End of a packet that is not streamed; code is the CONNACK return code
	task automatic finish_packet(logic [7:0] code);
		if (m_type == mqttp_pkg::TYPE_CONNACK && m_len >= 28'd2) begin
			if (code == 8'd0) begin
				m_link = mqttp_pkg::LINK_UP;
				add_due(mqttp_pkg::K_CONNECTED, 8'h00, 2'd0, 1'b0);
			end else begin
				drop_link();
				return;
			end
		end else if (m_type == mqttp_pkg::TYPE_PINGREQ) begin
			add_due(mqttp_pkg::K_SEND_PINGRSP, 8'h00, 2'd0, 1'b0);
		end
		m_phase = mqttp_pkg::PH_HEADER;
	endtask

	task automatic topic_done;
		if (m_body_left == 28'd0) begin
			add_due(mqttp_pkg::K_EMPTY_END, 8'h00, m_qos, 1'b1);
			m_phase = mqttp_pkg::PH_HEADER;
			return;
		end
		m_id_left = (m_qos != 2'd0 && m_body_left >= 28'd2) ? 2'd2 : 2'd0;
		m_phase = (m_id_left != 2'd0) ? mqttp_pkg::PH_ID : mqttp_pkg::PH_PAYLOAD;
	endtask

	task automatic body_in(logic [7:0] b);
		logic [27:0] offset;
		logic        last;
		logic [15:0] tl;
		offset = m_len - m_body_left;
		m_body_left = m_body_left - 28'd1;
		last = (m_body_left == 28'd0);
		case (m_phase)
			mqttp_pkg::PH_SKIP: begin
				if (m_type == mqttp_pkg::TYPE_CONNACK && offset == 28'd1) m_ack_code = b;
				if (last) finish_packet(m_ack_code);
			end
			mqttp_pkg::PH_TOPIC_HI: begin
				m_topic_hi = b;
				m_phase = last ? mqttp_pkg::PH_HEADER : mqttp_pkg::PH_TOPIC_LO;
			end
			mqttp_pkg::PH_TOPIC_LO: begin
				tl = {m_topic_hi, b};
				if ({12'd0, tl} > m_body_left) begin
					m_pub_ok = 1'b0;
					m_phase = last ? mqttp_pkg::PH_HEADER : mqttp_pkg::PH_SKIP;
				end else begin
					m_pub_ok = 1'b1;
					m_topic_left = tl;
					if (tl != 16'd0) m_phase = mqttp_pkg::PH_TOPIC;
					else topic_done();
				end
			end
			mqttp_pkg::PH_TOPIC: begin
				add_due(mqttp_pkg::K_TOPIC, b, m_qos, 1'b0);
				m_topic_left = m_topic_left - 16'd1;
				if (m_topic_left == 16'd0) topic_done();
				else if (last) m_phase = mqttp_pkg::PH_HEADER;
			end
			mqttp_pkg::PH_ID: begin
				m_id_left = m_id_left - 2'd1;
				if (last) begin
					add_due(mqttp_pkg::K_EMPTY_END, 8'h00, m_qos, 1'b1);
					m_phase = mqttp_pkg::PH_HEADER;
				end else if (m_id_left == 2'd0) begin
					m_phase = mqttp_pkg::PH_PAYLOAD;
				end
			end
			mqttp_pkg::PH_PAYLOAD: begin
				add_due(mqttp_pkg::K_PAYLOAD, b, m_qos, last);
				if (last) m_phase = mqttp_pkg::PH_HEADER;
			end
			default: m_phase = mqttp_pkg::PH_HEADER;
		endcase
	endtask

	task automatic byte_in(logic [7:0] b);
		logic [2:0] g;
		if (m_phase == mqttp_pkg::PH_HEADER) begin
			m_type     = b[7:4];
			m_qos      = b[2:1];
			m_len      = '0;
			m_groups   = '0;
			m_pub_ok   = 1'b0;
			m_ack_code = '0;
			m_phase    = mqttp_pkg::PH_LENGTH;
		end else if (m_phase == mqttp_pkg::PH_LENGTH) begin
			g = m_groups;
			if (g < 3'd4) m_len = m_len + (28'(b[6:0]) << (7 * g));
			m_groups = g + 3'd1;
			if (!b[7]) begin
				m_body_left = m_len;
				if (m_len == 28'd0) finish_packet(8'd0);
				else m_phase = (m_type == mqttp_pkg::TYPE_PUBLISH) ? mqttp_pkg::PH_TOPIC_HI
					: mqttp_pkg::PH_SKIP;
			end else if (m_groups >= mqttp_pkg::MAX_LENGTH_GROUPS) begin
				add_due(mqttp_pkg::K_MALFORMED, 8'h00, 2'd0, 1'b0);
				m_phase = mqttp_pkg::PH_HEADER;
			end
		end else begin
			body_in(b);
		end
	endtask

	task automatic parse_step(logic [1:0] op, logic [7:0] b);
		step_results = 0;
		case (op)
			mqttp_pkg::OP_BYTE: begin
				if (m_link != mqttp_pkg::LINK_DOWN) begin
					useful_items++;
					byte_in(b);
				end
			end
			mqttp_pkg::OP_OPEN: begin
				if (m_link == mqttp_pkg::LINK_DOWN) begin
					useful_items++;
					m_link = mqttp_pkg::LINK_CONNECTING;
					clear_mirror();
				end
			end
			mqttp_pkg::OP_CLOSE: begin
				if (m_link != mqttp_pkg::LINK_DOWN) useful_items++;
				drop_link();
			end
			default: ;
		endcase
	endtask

	// Sender: bursts of items with random gaps between them
	task automatic send_item(input logic [1:0] op, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		operation <= op;
		rx_byte   <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_step(op, b);
		burst_left--;
	endtask

	task automatic send_bytes;
		foreach (pkt_bytes[i]) send_item(mqttp_pkg::OP_BYTE, pkt_bytes[i]);
		pkt_bytes.delete();
	endtask

	task automatic wait_for_results;
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// Remaining length, sometimes padded with extra zero groups (n < 128)
	task automatic push_length(int n);
		int groups;
		groups = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
		if (groups == 1) begin
			add_byte(8'(n & 127));
		end else begin
			add_byte(8'(128 | (n & 127)));
			repeat (groups - 2) add_byte(8'h80);
			add_byte(8'h00);
		end
	endtask

	task automatic push_random(int count);
		repeat (count) add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic connack_ok;
		pkt_bytes = {{mqttp_pkg::TYPE_CONNACK, 4'h0}, 8'h02, 8'h00, 8'h00};
		send_bytes();
	endtask

	task automatic test_link_events;
		send_item(mqttp_pkg::OP_CLOSE, 8'h00);
		send_item(mqttp_pkg::OP_BYTE, 8'hFF);
		send_item(OP_UNUSED, 8'hAA);
		send_item(mqttp_pkg::OP_OPEN, 8'h00);
		send_item(mqttp_pkg::OP_OPEN, 8'h55);
		send_item(mqttp_pkg::OP_CLOSE, 8'h00);
		wait_for_results();
	endtask

	task automatic test_connack;
		send_item(mqttp_pkg::OP_OPEN, 8'h00);
		pkt_bytes = {{mqttp_pkg::TYPE_CONNACK, 4'h0}, 8'h02, 8'h00, 8'h05};
		send_bytes();
		send_item(mqttp_pkg::OP_OPEN, 8'h00);
		// body too short to carry a return code
		pkt_bytes = {{mqttp_pkg::TYPE_CONNACK, 4'h0}, 8'h01, 8'h00};
		send_bytes();
		connack_ok();
		wait_for_results();
	endtask

	task automatic test_publish_forms;
		// qos 1, one topic byte, id only: empty payload
		pkt_bytes = {{mqttp_pkg::TYPE_PUBLISH, 4'h3}, 8'h05, 8'h00, 8'h01, 8'h41, 8'h12,
			8'h34};
		send_bytes();
		pkt_bytes = {{mqttp_pkg::TYPE_PUBLISH, 4'h0}, 8'h04, 8'h00, 8'h00, 8'hFF, 8'h00};
		send_bytes();
		// qos 2 with a single byte after the topic: that byte is payload
		pkt_bytes = {{mqttp_pkg::TYPE_PUBLISH, 4'h4}, 8'h03, 8'h00, 8'h00, 8'h80};
		send_bytes();
		pkt_bytes = {{mqttp_pkg::TYPE_PUBLISH, 4'hF}, 8'h01, 8'h7F};
		send_bytes();
		pkt_bytes = {{mqttp_pkg::TYPE_PUBLISH, 4'h0}, 8'h03, 8'h00, 8'h05, 8'h01};
		send_bytes();
		wait_for_results();
	endtask

	task automatic test_ping_malformed_close;
		pkt_bytes = {{mqttp_pkg::TYPE_PINGREQ, 4'h0}, 8'h00};
		send_bytes();
		pkt_bytes = {{mqttp_pkg::TYPE_PUBLISH, 4'h0}, 8'h80, 8'hFF, 8'h80, 8'h80};
		send_bytes();
		send_item(mqttp_pkg::OP_CLOSE, 8'h00);
		wait_for_results();
	endtask

	task automatic build_publish;
		logic [3:0] flags;
		int tl, pl, idn;
		flags = 4'($urandom_range(0, 15));
		tl  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
		pl  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
		idn = (flags[2:1] != 2'd0) ? 2 : 0;
		add_byte({mqttp_pkg::TYPE_PUBLISH, flags});
		push_length(2 + tl + idn + pl);
		add_byte(8'h00);
		add_byte(8'(tl));
		push_random(tl + idn + pl);
	endtask

	task automatic build_short_publish;
		int tl, k;
		add_byte({mqttp_pkg::TYPE_PUBLISH, 4'($urandom_range(0, 15))});
		case ($urandom_range(0, 3))
			0: add_byte(8'h00);
			1: begin
				add_byte(8'h01);
				push_random(1);
			end
			2: begin
				// topic length beyond what the body holds
				k = $urandom_range(0, 4);
				push_length(2 + k);
				if ($urandom_range(0, 1) == 0) begin
					add_byte(8'($urandom_range(1, 255)));
					push_random(1);
				end else begin
					add_byte(8'h00);
					add_byte(8'($urandom_range(k + 1, 255)));
				end
				push_random(k);
			end
			default: begin
				tl = $urandom_range(0, 3);
				pkt_bytes[0][2:1] = 2'($urandom_range(1, 3));
				push_length(3 + tl);
				add_byte(8'h00);
				add_byte(8'(tl));
				push_random(tl + 1);
			end
		endcase
	endtask

	task automatic restart_link;
		if (m_link != mqttp_pkg::LINK_DOWN)
			send_item(mqttp_pkg::OP_CLOSE, 8'($urandom_range(0, 255)));
		send_item(mqttp_pkg::OP_OPEN, 8'($urandom_range(0, 255)));
		connack_ok();
	endtask

	task automatic test_random_traffic;
		int start;
		int pick;
		int rl;
		start = useful_items;
		while (useful_items - start < 500) begin
			if (m_link != mqttp_pkg::LINK_UP || m_phase != mqttp_pkg::PH_HEADER) restart_link();
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				build_publish();
			end else if (pick < 58) begin
				add_byte({mqttp_pkg::TYPE_PINGREQ, 4'($urandom_range(0, 15))});
				rl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
				push_length(rl);
				push_random(rl);
			end else if (pick < 66) begin
				push_random(1);
				rl = $urandom_range(0, 4);
				push_length(rl);
				push_random(rl);
			end else if (pick < 72) begin
				add_byte({mqttp_pkg::TYPE_CONNACK, 4'($urandom_range(0, 15))});
				rl = $urandom_range(2, 4);
				push_length(rl);
				push_random(1);
				add_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
				push_random(rl - 2);
			end else if (pick < 78) begin
				build_short_publish();
			end else if (pick < 82) begin
				push_random(1);
				repeat (4) add_byte(8'($urandom_range(128, 255)));
			end else if (pick < 86) begin
				send_item(mqttp_pkg::OP_CLOSE, 8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				// huge length cut off by a link close
				push_random(1);
				repeat (3) add_byte(8'($urandom_range(128, 255)));
				add_byte(8'($urandom_range(0, 127)));
				push_random($urandom_range(0, 5));
				send_bytes();
				send_item(mqttp_pkg::OP_CLOSE, 8'($urandom_range(0, 255)));
			end
			send_bytes();
			if ($urandom_range(0, 39) == 0) wait_for_results();
		end
	endtask

	// Receiver stall pattern: one of four modes, picked anew at random as stall_cycle counts on
	int stall_cycle = 0;
	int stall_mode = 0;
	always @(posedge clk) begin
		if (stall_cycle % 80 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ((stall_cycle % 12) < 8);
		endcase
		stall_cycle++;
	end

	task automatic flag_error(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	always @(posedge clk) begin : check_results
		mqttp_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				flag_error($sformatf("result %0d unexpected: kind %0d data %02h qos %0d eom %0d",
					results_seen, kind, data_byte, qos_level, end_of_message));
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind || data_byte !== want.data || qos_level !== want.qos
						|| end_of_message !== want.eom)
					flag_error($sformatf({"result %0d: expected kind %0d data %02h qos %0d ",
						"eom %0d, got kind %0d data %02h qos %0d eom %0d"}, results_seen,
						want.kind, want.data, want.qos, want.eom,
						kind, data_byte, qos_level, end_of_message));
			end
			results_seen++;
		end
	end

	initial begin
		#(5_000_000);
		$display("mqtt_receive_packet_parser: mismatch");
		$finish;
	end

	initial begin
		m_link = mqttp_pkg::LINK_DOWN;
		clear_mirror();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_link_events();
		test_connack();
		test_publish_forms();
		test_ping_malformed_close();
		test_random_traffic();
		wait_for_results();
		repeat (6) @(posedge clk);
		if (fail_count == 0) begin
			$display("mqtt_receive_packet_parser: match");
		end else begin
			$display("mqtt_receive_packet_parser: mismatch");
		end
		$finish;
	end

endmodule

// ===== mqtt_receive_packet_parser.f =====
hdl/mqttp_pkg.sv
hdl/mqttp_front.sv
hdl/mqttp_queue.sv
hdl/mqttp_back.sv
hdl/mqtt_receive_packet_parser.sv
verif/tb_top.sv
